[rtl/gbn_pkg.sv]
// Shared types, constants and the remainder step of the go-back-n sender window.
`default_nettype none

package gbn_pkg;

    localparam int SEQ_W            = 16;
    localparam int LEN_W            = 10;
    localparam int LIMIT_W          = 5;
    localparam int DIV_W            = SEQ_W + 1;
    localparam int BIT_IDX_W        = $clog2(DIV_W);
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_MAX_PAYLOAD  = 512;

    localparam logic [SEQ_W-1:0]   RESET_INITIAL_SEQ = 16'd0;
    localparam logic [SEQ_W-1:0]   RESET_MODULUS     = 16'd25601;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT       = 5'd10;
    localparam logic [SEQ_W-1:0]   MIN_MODULUS       = 16'd2;

    typedef enum logic [1:0] {
        FUNC_NEW     = 2'd0,
        FUNC_ACK     = 2'd1,
        FUNC_TIMEOUT = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_REFUSED = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_RETX    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_INITIAL_SEQ  = 2'd0,
        REG_SEQ_MODULUS  = 2'd1,
        REG_WINDOW_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_CLEAR = 2'd1,
        CELL_STEP  = 2'd2,
        CELL_SHIFT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic [SEQ_W-1:0]       modulus;
    } cell_ctrl_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] rem;
    } entry_t;

    // One restoring step: shift in the next dividend bit, subtract the modulus if it fits.
    function automatic logic [SEQ_W-1:0] rem_step(
        input logic [SEQ_W-1:0] r,
        input logic             b,
        input logic [SEQ_W-1:0] m
    );
        logic [SEQ_W:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/gbn_cell.sv]
// One window cell: holds a segment, reduces its end number, shifts toward the head.
`default_nettype none

module gbn_cell (
    input  wire logic               clk,
    input  wire gbn_pkg::cell_ctrl_t ctrl,
    input  wire logic               load,
    input  wire gbn_pkg::entry_t    load_entry,
    input  wire gbn_pkg::entry_t    nbr_entry,
    output gbn_pkg::entry_t         entry
);
    import gbn_pkg::*;

    entry_t           entry_reg;
    entry_t           entry_next;
    logic [DIV_W-1:0] seg_end;

    always_comb
    begin
        seg_end    = DIV_W'(entry_reg.seq) + DIV_W'(entry_reg.len);
        entry_next = entry_reg;
        if (load)
        begin
            entry_next = load_entry;
        end
        else
        begin
            unique case (ctrl.op)
                CELL_HOLD:  entry_next = entry_reg;
                CELL_CLEAR: entry_next.rem = '0;
                CELL_STEP:  entry_next.rem = rem_step(entry_reg.rem, seg_end[ctrl.bit_idx],
                                                      ctrl.modulus);
                CELL_SHIFT: entry_next = nbr_entry;
                default:    entry_next = entry_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[rtl/go_back_n_sender_window.sv]
// Top level of the go-back-n sender window: config registers, control sequencer, cell chain.
//
// Go-back-n sender window. Each input transfer carries a function code in tuser: a new
// segment gets the next sequence number, is stored at the tail of the window and comes
// back as a transmit result (or a refused result when the window limit is reached); an
// acknowledgement frees the oldest outstanding segment whose end, (seq + length) mod
// seq_modulus, equals ack_number, together with all older ones, and reports how many
// were freed; a timeout replays every outstanding segment oldest first, tlast on the
// final one. The window is a row of WINDOW_DEPTH cells, the head in cell 0; the cells
// rotate the outstanding prefix one place per cycle (in a replay only while the output
// is free), so every search and every replay walks the window through cell 0. The block
// works on one item at a time. A new segment passes through accept, 17 steps of the
// bit-serial remainder that wraps the next sequence number, and result; a refused one
// through accept and result. An acknowledgement passes through accept, 17 remainder
// steps run in all cells at once, one walk step for each segment up to and including
// the match (in-flight + 1 when none matches), and result. A timeout gives one
// retransmit transfer per cycle while m_axis_tready stays high, and no result when
// nothing is in flight. A write of initial_seq in the idle state runs the same 17-step
// remainder and holds s_axis_tready low meanwhile. The output register lets the next
// item be accepted while the last result still waits to be taken. Registers: 0x0
// initial_seq, 0x4 seq_modulus (values below 2 act as 2), 0x8 window_limit (0 acts as
// 1, values above WINDOW_DEPTH act as WINDOW_DEPTH); pready is always high.
`default_nettype none

module go_back_n_sender_window #(
    parameter int  WINDOW_DEPTH = gbn_pkg::DEF_WINDOW_DEPTH,
    parameter int  MAX_PAYLOAD  = gbn_pkg::DEF_MAX_PAYLOAD,
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1),
    localparam int S_TDATA_W    = ((gbn_pkg::LEN_W + gbn_pkg::SEQ_W + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((gbn_pkg::SEQ_W + gbn_pkg::LEN_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gbn_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gbn_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gbn_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    // input items
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]           s_axis_tdata,  // seg_length, ack_number
    input  wire logic [1:0]                     s_axis_tuser,  // func
    // result items
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [M_TDATA_W-1:0]           m_axis_tdata,  // seq_number, out_length,
                                                               // freed_count, in_flight
    output logic      [1:0]                     m_axis_tuser,  // kind
    output logic                                m_axis_tlast
);
    import gbn_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CFG_REM,
        ST_SEQ_REM,
        ST_ACK_REM,
        ST_ACK_WALK,
        ST_REPLAY,
        ST_RESULT
    } state_t;

    // registers
    state_t               state_reg,        state_next;
    logic [SEQ_W-1:0]     initial_seq_reg,  initial_seq_next;
    logic [SEQ_W-1:0]     seq_modulus_reg,  seq_modulus_next;
    logic [LIMIT_W-1:0]   window_limit_reg, window_limit_next;
    logic [SEQ_W-1:0]     next_seq_reg,     next_seq_next;
    logic [CNT_W-1:0]     cnt_reg,          cnt_next;
    logic [CNT_W-1:0]     q_reg,            q_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg,      bit_idx_next;
    logic [DIV_W-1:0]     div_reg,          div_next;
    logic [SEQ_W-1:0]     rem_reg,          rem_next;
    logic [SEQ_W-1:0]     mod_reg,          mod_next;
    logic [SEQ_W-1:0]     ack_reg,          ack_next;
    kind_t                res_kind_reg,     res_kind_next;
    logic [SEQ_W-1:0]     res_seq_reg,      res_seq_next;
    logic [LEN_W-1:0]     res_len_reg,      res_len_next;
    logic [CNT_W-1:0]     res_freed_reg,    res_freed_next;
    logic                 m_valid_reg,      m_valid_next;
    kind_t                m_kind_reg,       m_kind_next;
    logic [SEQ_W-1:0]     m_seq_reg,        m_seq_next;
    logic [LEN_W-1:0]     m_len_reg,        m_len_next;
    logic [CNT_W-1:0]     m_freed_reg,      m_freed_next;
    logic [CNT_W-1:0]     m_flight_reg,     m_flight_next;
    logic                 m_last_reg,       m_last_next;

    // decoded inputs and helpers
    logic                 cfg_wr;
    logic [1:0]           wr_idx;
    logic                 cfg_init_wr;
    logic                 in_fire;
    logic [LEN_W-1:0]     in_len;
    logic [SEQ_W-1:0]     in_ack;
    logic [LEN_W-1:0]     len_clamped;
    logic [SEQ_W-1:0]     eff_mod;
    logic [LIMIT_W-1:0]   lim_raw;
    logic [CNT_W-1:0]     eff_limit;
    logic                 full;
    logic                 out_free;
    logic [SEQ_W-1:0]     rem_new;
    logic [CNT_W-1:0]     q_inc;
    logic [CNT_W-1:0]     cnt_m1;
    logic                 load_new;

    cell_ctrl_t           cell_ctrl;
    entry_t               load_entry;
    entry_t               entries [WINDOW_DEPTH];
    entry_t               nbrs    [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] loads;

    // configuration port
    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite & pready;
    assign wr_idx      = paddr[3:2];
    assign cfg_init_wr = cfg_wr && (wr_idx == REG_INITIAL_SEQ);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_INITIAL_SEQ:  prdata = APB_DATA_W'(initial_seq_reg);
            REG_SEQ_MODULUS:  prdata = APB_DATA_W'(seq_modulus_reg);
            REG_WINDOW_LIMIT: prdata = APB_DATA_W'(window_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // effective modulus and window limit
    assign eff_mod = (seq_modulus_reg < MIN_MODULUS) ? MIN_MODULUS : seq_modulus_reg;
    assign lim_raw = (window_limit_reg == '0) ? LIMIT_W'(1) : window_limit_reg;
    assign eff_limit = (int'(lim_raw) > WINDOW_DEPTH) ? CNT_W'(WINDOW_DEPTH)
                                                      : CNT_W'(lim_raw);

    // input decode; hold off items while an initial_seq write starts its reduction
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_init_wr;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_len        = s_axis_tdata[LEN_W-1:0];
    assign in_ack        = s_axis_tdata[LEN_W +: SEQ_W];
    assign len_clamped   = (int'(in_len) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : in_len;

    assign full     = (cnt_reg >= eff_limit);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign rem_new  = rem_step(rem_reg, div_reg[bit_idx_reg], mod_reg);
    assign q_inc    = q_reg + CNT_W'(1);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign load_new = in_fire && (s_axis_tuser == FUNC_NEW) && !full;

    // cell chain control: clear and step the end remainders, rotate the outstanding prefix
    always_comb
    begin
        cell_ctrl.bit_idx = bit_idx_reg;
        cell_ctrl.modulus = mod_reg;
        cell_ctrl.op      = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser == FUNC_ACK))
                begin
                    cell_ctrl.op = CELL_CLEAR;
                end
            end
            ST_ACK_REM:
            begin
                cell_ctrl.op = CELL_STEP;
            end
            ST_ACK_WALK:
            begin
                if (q_reg != cnt_reg)
                begin
                    cell_ctrl.op = CELL_SHIFT;
                end
            end
            ST_REPLAY:
            begin
                if (out_free)
                begin
                    cell_ctrl.op = CELL_SHIFT;
                end
            end
            default:
            begin
                cell_ctrl.op = CELL_HOLD;
            end
        endcase
    end

    assign load_entry.seq = next_seq_reg;
    assign load_entry.len = len_clamped;
    assign load_entry.rem = '0;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        // append at the tail, which sits right behind the outstanding prefix
        assign loads[i] = load_new && (cnt_reg[IDX_W-1:0] == IDX_W'(i));

        // the last outstanding cell wraps around to the head
        if (i < WINDOW_DEPTH - 1)
        begin : g_mid
            assign nbrs[i] = (cnt_m1 == CNT_W'(i)) ? entries[0] : entries[i+1];
        end
        else
        begin : g_end
            assign nbrs[i] = entries[0];
        end

        gbn_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .load       (loads[i]),
            .load_entry (load_entry),
            .nbr_entry  (nbrs[i]),
            .entry      (entries[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        initial_seq_next  = initial_seq_reg;
        seq_modulus_next  = seq_modulus_reg;
        window_limit_next = window_limit_reg;
        next_seq_next     = next_seq_reg;
        cnt_next          = cnt_reg;
        q_next            = q_reg;
        bit_idx_next      = bit_idx_reg;
        div_next          = div_reg;
        rem_next          = rem_reg;
        mod_next          = mod_reg;
        ack_next          = ack_reg;
        res_kind_next     = res_kind_reg;
        res_seq_next      = res_seq_reg;
        res_len_next      = res_len_reg;
        res_freed_next    = res_freed_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;
        m_kind_next       = m_kind_reg;
        m_seq_next        = m_seq_reg;
        m_len_next        = m_len_reg;
        m_freed_next      = m_freed_reg;
        m_flight_next     = m_flight_reg;
        m_last_next       = m_last_reg;

        // register writes
        if (cfg_wr)
        begin
            unique case (wr_idx)
                REG_INITIAL_SEQ:  initial_seq_next  = pwdata[SEQ_W-1:0];
                REG_SEQ_MODULUS:  seq_modulus_next  = pwdata[SEQ_W-1:0];
                REG_WINDOW_LIMIT: window_limit_next = pwdata[LIMIT_W-1:0];
                default:          initial_seq_next  = initial_seq_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_init_wr)
                begin
                    // reduce the new initial sequence number by the modulus
                    div_next     = DIV_W'(pwdata[SEQ_W-1:0]);
                    rem_next     = '0;
                    bit_idx_next = BIT_IDX_W'(DIV_W - 1);
                    mod_next     = eff_mod;
                    state_next   = ST_CFG_REM;
                end
                else if (in_fire)
                begin
                    mod_next       = eff_mod;
                    ack_next       = in_ack;
                    rem_next       = '0;
                    bit_idx_next   = BIT_IDX_W'(DIV_W - 1);
                    res_seq_next   = next_seq_reg;
                    res_len_next   = len_clamped;
                    res_freed_next = '0;
                    q_next         = '0;
                    unique case (s_axis_tuser)
                        FUNC_NEW:
                        begin
                            if (full)
                            begin
                                res_kind_next = KIND_REFUSED;
                                state_next    = ST_RESULT;
                            end
                            else
                            begin
                                res_kind_next = KIND_TX;
                                cnt_next      = cnt_reg + CNT_W'(1);
                                div_next      = DIV_W'(next_seq_reg) + DIV_W'(len_clamped);
                                state_next    = ST_SEQ_REM;
                            end
                        end
                        FUNC_ACK:
                        begin
                            res_kind_next = KIND_ACK;
                            res_seq_next  = '0;
                            res_len_next  = '0;
                            state_next    = ST_ACK_REM;
                        end
                        FUNC_TIMEOUT:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_REPLAY;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CFG_REM:
            begin
                rem_next     = rem_new;
                bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                if (bit_idx_reg == '0)
                begin
                    next_seq_next = rem_new;
                    state_next    = ST_IDLE;
                end
            end

            ST_SEQ_REM:
            begin
                rem_next     = rem_new;
                bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                if (bit_idx_reg == '0)
                begin
                    next_seq_next = rem_new;
                    state_next    = ST_RESULT;
                end
            end

            ST_ACK_REM:
            begin
                bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                if (bit_idx_reg == '0)
                begin
                    state_next = ST_ACK_WALK;
                end
            end

            ST_ACK_WALK:
            begin
                // cell 0 holds the segment q places from the head
                if (q_reg == cnt_reg)
                begin
                    // full turn without a match: window is back in place, free nothing
                    res_freed_next = '0;
                    state_next     = ST_RESULT;
                end
                else if (entries[0].rem == ack_reg)
                begin
                    // freed segments have rotated behind the survivors: drop them
                    cnt_next       = cnt_reg - q_inc;
                    res_freed_next = q_inc;
                    state_next     = ST_RESULT;
                end
                else
                begin
                    q_next = q_inc;
                end
            end

            ST_REPLAY:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_RETX;
                    m_seq_next    = entries[0].seq;
                    m_len_next    = entries[0].len;
                    m_freed_next  = '0;
                    m_flight_next = cnt_reg;
                    m_last_next   = (q_inc == cnt_reg);
                    q_next        = q_inc;
                    if (q_inc == cnt_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = res_kind_reg;
                    m_seq_next    = res_seq_reg;
                    m_len_next    = res_len_reg;
                    m_freed_next  = res_freed_reg;
                    m_flight_next = cnt_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            initial_seq_reg  <= RESET_INITIAL_SEQ;
            seq_modulus_reg  <= RESET_MODULUS;
            window_limit_reg <= RESET_LIMIT;
            next_seq_reg     <= RESET_INITIAL_SEQ;
            cnt_reg          <= '0;
            q_reg            <= '0;
            bit_idx_reg      <= '0;
            div_reg          <= '0;
            rem_reg          <= '0;
            mod_reg          <= MIN_MODULUS;
            ack_reg          <= '0;
            res_kind_reg     <= KIND_TX;
            res_seq_reg      <= '0;
            res_len_reg      <= '0;
            res_freed_reg    <= '0;
            m_valid_reg      <= 1'b0;
            m_kind_reg       <= KIND_TX;
            m_seq_reg        <= '0;
            m_len_reg        <= '0;
            m_freed_reg      <= '0;
            m_flight_reg     <= '0;
            m_last_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            initial_seq_reg  <= initial_seq_next;
            seq_modulus_reg  <= seq_modulus_next;
            window_limit_reg <= window_limit_next;
            next_seq_reg     <= next_seq_next;
            cnt_reg          <= cnt_next;
            q_reg            <= q_next;
            bit_idx_reg      <= bit_idx_next;
            div_reg          <= div_next;
            rem_reg          <= rem_next;
            mod_reg          <= mod_next;
            ack_reg          <= ack_next;
            res_kind_reg     <= res_kind_next;
            res_seq_reg      <= res_seq_next;
            res_len_reg      <= res_len_next;
            res_freed_reg    <= res_freed_next;
            m_valid_reg      <= m_valid_next;
            m_kind_reg       <= m_kind_next;
            m_seq_reg        <= m_seq_next;
            m_len_reg        <= m_len_next;
            m_freed_reg      <= m_freed_next;
            m_flight_reg     <= m_flight_next;
            m_last_reg       <= m_last_next;
        end
    end

    // output channel
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_flight_reg, m_freed_reg, m_len_reg, m_seq_reg});

endmodule

`default_nettype wire
